@@ rtl/core/mcg_pkg.sv @@
// Shared types and constants of the Max-Cut energy and gradient unit.
package mcg_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR2,
    ST_XI,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  localparam logic [1:0] OP_WEIGHT  = 2'd0;
  localparam logic [1:0] OP_ASSIGN  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [6:0] NODE_COUNT_RST = 7'd64;
  localparam logic signed [16:0] HALF_Q14 = 17'sd8192;
  localparam logic signed [34:0] QUARTER_Q28 = 35'sd67108864;

  // Controls from the sequencer to the multiply-accumulate datapath.
  typedef struct packed {
    logic issue;   // a weight/assignment pair is read this cycle
    logic upper;   // the pair lies above the diagonal (counts toward energy)
    logic xi_rd;   // the row node's assignment is read this cycle
    logic gclr;    // clear the gradient accumulator
    logic eclr;    // clear the energy accumulator
  } dp_ctl_t;

endpackage

@@ rtl/core/mcg_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
module mcg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/mcg_datapath.sv @@
// Multiply-accumulate pipeline for the gradient and energy sums.
module mcg_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mcg_pkg::dp_ctl_t       ctl,
  input  logic signed [15:0]     w_rd,
  input  logic signed [15:0]     x_rd,
  output logic signed [47:0]     gacc,
  output logic signed [63:0]     eacc,
  output logic                   busy
);
  import mcg_pkg::*;

  logic v0_r, en0_r, dl_r;
  logic v1_r, en1_r, v2_r;
  logic signed [16:0] di_r;
  logic signed [16:0] dj;
  logic signed [32:0] gp, gp_r;
  logic signed [33:0] q, q_r;
  logic signed [15:0] w1_r;
  logic signed [50:0] ep_r;
  logic signed [47:0] gacc_r;
  logic signed [63:0] eacc_r;

  assign dj = 17'(x_rd) - HALF_Q14;
  assign gp = 33'(w_rd) * 33'(dj);
  assign q  = 34'(di_r) * 34'(dj);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      en0_r  <= 1'b0;
      dl_r   <= 1'b0;
      v1_r   <= 1'b0;
      en1_r  <= 1'b0;
      v2_r   <= 1'b0;
      gacc_r <= '0;
      eacc_r <= '0;
    end else begin
      v0_r  <= ctl.issue;
      en0_r <= ctl.upper;
      dl_r  <= ctl.xi_rd;
      v1_r  <= v0_r;
      en1_r <= v0_r & en0_r;
      v2_r  <= en1_r;
      if (ctl.gclr) begin
        gacc_r <= '0;
      end else if (v1_r) begin
        gacc_r <= gacc_r + 48'(gp_r);
      end
      if (ctl.eclr) begin
        eacc_r <= '0;
      end else if (v2_r) begin
        eacc_r <= eacc_r + 64'(ep_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dl_r) begin
      di_r <= dj;
    end
    gp_r <= gp;
    q_r  <= q;
    w1_r <= w_rd;
    ep_r <= 51'(w1_r) * 51'(35'(q_r) - QUARTER_Q28);
  end

  assign gacc = gacc_r;
  assign eacc = eacc_r;
  assign busy = v0_r | v1_r | v2_r;

endmodule

@@ rtl/core/maxcut_energy_gradient_unit.sv @@
// Top level of the Max-Cut energy and gradient unit: sequencer, memories, output register.
//
// Channels: in_* takes command words (tuser = op; tdata = row, col, value),
// out_* delivers one word per node after a compute command, and cfg_* writes
// node_count (clamped to 2..MAX_NODES when used).
// Op 0 writes a weight into both mirrored matrix entries; op 1 writes an
// assignment value. A write on the diagonal or past MAX_NODES changes nothing.
// Op 2 walks row i of the weight memory, one entry per cycle through a single
// read port and one multiply-accumulate pipeline. Each row takes an assignment
// read, its n entries, a drain of the pipeline and an emit.
// Commands are taken one at a time; in_tready is low while a command runs.
// If the receiver stalls, the sequencer waits before emitting the next row;
// the output register holds its word until taken.
// After reset the weight memory is cleared, one entry a cycle, over all
// 2^(2*ceil(log2(MAX_NODES))) entries (4096 at the default); in_tready stays
// low meanwhile. Configuration writes are always taken.
module maxcut_energy_gradient_unit #(
  parameter int MAX_NODES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // row[5:0], col[11:6], value[27:12], zero pad
  input  logic [1:0]   in_tuser,   // op[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // node_index[5:0], gradient[53:6], energy[117:54], pad
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [6:0]   cfg_data
);
  import mcg_pkg::*;

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int AW = 2 * IW;
  localparam int WDEPTH = 1 << AW;
  localparam logic [8:0] MAXN = 9'(MAX_NODES);

  state_t state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [6:0] nc_r;
  logic [IW-1:0] wr_r_r, wr_c_r;
  logic [15:0] wr_v_r;

  logic [5:0] in_row, in_col;
  logic [15:0] in_value;
  logic in_acc, wr_ok, out_load;
  logic [8:0] n_act;
  logic [IW-1:0] nm1;

  logic w_we, x_we;
  logic [AW-1:0] w_waddr, w_raddr;
  logic [15:0] w_wdata, w_rd, x_rd;
  logic [IW-1:0] x_raddr;

  dp_ctl_t ctl;
  logic signed [47:0] gacc;
  logic signed [63:0] eacc;
  logic busy;

  logic out_valid_r;
  logic [5:0] out_node_r;
  logic [47:0] out_grad_r;
  logic [63:0] out_energy_r;
  logic out_last_r;

  assign in_row   = in_tdata[5:0];
  assign in_col   = in_tdata[11:6];
  assign in_value = in_tdata[27:12];
  assign in_acc   = in_tvalid & in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign wr_ok = (in_row != in_col) && (9'(in_row) < MAXN) && (9'(in_col) < MAXN);

  always_comb begin
    if (nc_r < 7'd2) begin
      n_act = 9'd2;
    end else if (9'(nc_r) > MAXN) begin
      n_act = MAXN;
    end else begin
      n_act = 9'(nc_r);
    end
  end
  assign nm1 = IW'(n_act - 9'd1);

  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == '1) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc && in_tuser == OP_WEIGHT && wr_ok) begin
          state_nxt = ST_WR2;
        end else if (in_acc && in_tuser == OP_COMPUTE) begin
          state_nxt = ST_XI;
        end
      end
      ST_WR2:   state_nxt = ST_IDLE;
      ST_XI:    state_nxt = ST_RUN;
      ST_RUN:   if (j_r == nm1) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!busy) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = (i_r == nm1) ? ST_IDLE : ST_XI;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Memory, datapath and counter controls.
  always_comb begin
    w_we    = 1'b0;
    w_waddr = clr_r;
    w_wdata = '0;
    x_we    = 1'b0;
    x_raddr = j_r;
    w_raddr = {i_r, j_r};
    ctl     = '0;
    i_nxt   = i_r;
    j_nxt   = j_r;
    clr_nxt = clr_r;
    case (state_r)
      ST_CLEAR: begin
        w_we    = 1'b1;
        clr_nxt = clr_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_acc && in_tuser == OP_WEIGHT && wr_ok) begin
          w_we    = 1'b1;
          w_waddr = {IW'(in_row), IW'(in_col)};
          w_wdata = in_value;
        end
        if (in_acc && in_tuser == OP_ASSIGN && 9'(in_row) < MAXN) begin
          x_we = 1'b1;
        end
        if (in_acc && in_tuser == OP_COMPUTE) begin
          ctl.eclr = 1'b1;
          i_nxt    = '0;
        end
      end
      ST_WR2: begin
        w_we    = 1'b1;
        w_waddr = {wr_c_r, wr_r_r};
        w_wdata = wr_v_r;
      end
      ST_XI: begin
        x_raddr   = i_r;
        ctl.xi_rd = 1'b1;
        ctl.gclr  = 1'b1;
        j_nxt     = '0;
      end
      ST_RUN: begin
        ctl.issue = 1'b1;
        ctl.upper = (j_r > i_r);
        j_nxt     = j_r + 1'b1;
      end
      ST_EMIT: begin
        if (out_load) begin
          i_nxt = i_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      nc_r        <= NODE_COUNT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      if (cfg_valid && cfg_ready) begin
        nc_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      wr_r_r <= IW'(in_row);
      wr_c_r <= IW'(in_col);
      wr_v_r <= in_value;
    end
    if (out_load) begin
      out_node_r   <= 6'(i_r);
      out_grad_r   <= gacc;
      out_energy_r <= (i_r == nm1) ? eacc : '0;
      out_last_r   <= (i_r == nm1);
    end
  end

  mcg_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rd)
  );

  mcg_ram #(.WIDTH(16), .DEPTH(1 << IW)) u_assign_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (IW'(in_row)),
    .wdata (in_value),
    .raddr (x_raddr),
    .rdata (x_rd)
  );

  mcg_datapath u_datapath (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .w_rd  (w_rd),
    .x_rd  (x_rd),
    .gacc  (gacc),
    .eacc  (eacc),
    .busy  (busy)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_energy_r, out_grad_r, out_node_r};
  assign out_tlast  = out_last_r;

  // A row is emitted only once its products have left the pipeline.
  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !busy)
    else $error("row emitted with multiply-accumulate pipeline still busy");

  // The column counter never passes the last active node.
  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (j_r <= nm1))
    else $error("column counter beyond node count");

  // The last word of a run goes back to idle after it is loaded.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && i_r == nm1) |=> (state_r == ST_IDLE && out_tlast))
    else $error("last word did not end the compute run");

endmodule
